// ===== src/oqsr_pkg.sv =====
// Shared types and constants for the ordered queue with search and remove.
package oqsr_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 256;
   localparam int FIELD_W = 8;
   localparam int ENTRY_W = 3 * FIELD_W;
   localparam int OCC_W = 9;

   typedef enum logic [1:0] {
      OP_APPEND   = 2'd0,
      OP_POP      = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_CONTAINS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic       latch_req;
      logic       do_append;
      logic       do_pop;
      logic       start_scan;
      logic       scan_en;
      logic       mark_hit;
      logic       shift_en;
      logic       dec_count;
      logic       res_set;
      status_type res_status;
      logic       res_found;
      logic       res_take_frame;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic   full;
      logic   empty;
      logic   cmp_valid;
      logic   cmp_hit;
      logic   cmp_at_end;
      op_type op;
   } stat_type;

endpackage

// ===== src/ordered_queue_search_remove.sv =====
// Top level: ordered queue of entries with append, pop, remove-by-match and contains.
// Append, pop and any operation on an empty queue go straight to the result state;
// contains scans from the head to the matching position (the last entry on a miss);
// remove scans the same way and, on a match, closes the gap up to the tail entry.
// One operation is in flight at a time; a new request waits for the last result's load.
// Reset clears head, count and handshake state; the entry memory is not cleared.
module ordered_queue_search_remove
   import oqsr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // entry_index[7:0], entry_page[15:8], entry_frame[23:16]
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // removed_frame[7:0], occupancy[16:8], zero[23:17]
   output logic [2:0]  rsp_tuser   // status[1:0], found[2]
);

   cmd_type            cmd;
   stat_type           stat;
   op_type             req_op;
   status_type         status;
   logic               found;
   logic [FIELD_W-1:0] removed_frame;
   logic [OCC_W-1:0]   occupancy;

   assign req_op = op_type'(req_tuser);

   // The controller only decides; every stored entry and counter lives in the datapath.
   oqsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   oqsr_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .entry_index   (req_tdata[7:0]),
      .entry_page    (req_tdata[15:8]),
      .entry_frame   (req_tdata[23:16]),
      .req_op        (req_op),
      .status        (status),
      .found         (found),
      .removed_frame (removed_frame),
      .occupancy     (occupancy)
   );

   // The result transaction is packed from the datapath's output register.
   assign rsp_tdata = {7'b0, occupancy, removed_frame};
   assign rsp_tuser = {found, status};

endmodule

// ===== src/oqsr_dpath.sv =====
// Datapath: entry memory, head and count, scan and shift pipeline, result registers.
module oqsr_dpath
   import oqsr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [FIELD_W-1:0] entry_index,
   input  logic [FIELD_W-1:0] entry_page,
   input  logic [FIELD_W-1:0] entry_frame,
   input  op_type             req_op,
   output status_type         status,
   output logic               found,
   output logic [FIELD_W-1:0] removed_frame,
   output logic [OCC_W-1:0]   occupancy
);

   localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == ADDR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + ADDR_W'(1);
      end
      return r;
   endfunction

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]  cmp_addr_ff;
   logic [CNT_W-1:0]   cmp_pos_ff;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   logic [ENTRY_W-1:0] key_ff;
   op_type             op_ff;

   status_type         res_status_ff;
   logic               res_found_ff;
   logic [FIELD_W-1:0] res_frame_ff;
   status_type         out_status_ff;
   logic               out_found_ff;
   logic [FIELD_W-1:0] out_frame_ff;
   logic [OCC_W-1:0]   out_occ_ff;

   logic [SUM_W-1:0]   tail_sum;
   logic [ADDR_W-1:0]  tail_addr;
   logic               shift_wr;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               match;

   // Tail position in the ring; head and count together stay below twice the depth.
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      end
      tail_addr = tail_sum[ADDR_W-1:0];
   end

   assign shift_wr  = cmd.shift_en && (cmp_pos_ff < count_ff);
   assign mem_we    = cmd.do_append || shift_wr;
   assign mem_waddr = cmd.do_append ? tail_addr : wr_addr_ff;
   assign mem_wdata = cmd.do_append ? {entry_index, entry_page, entry_frame} : rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_en) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      cmp_valid_in = cmd.scan_en;
      if (cmd.do_append) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.do_pop) begin
         head_in  = next_addr(head_ff);
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.start_scan) begin
         ptr_in = head_ff;
         pos_in = '0;
      end else if (cmd.scan_en) begin
         ptr_in = next_addr(ptr_ff);
         pos_in = pos_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      if (cmd.scan_en) begin
         cmp_addr_ff <= ptr_ff;
         cmp_pos_ff  <= pos_ff;
      end
      if (cmd.mark_hit) begin
         wr_addr_ff <= cmp_addr_ff;
      end else if (shift_wr) begin
         wr_addr_ff <= next_addr(wr_addr_ff);
      end
      if (cmd.latch_req) begin
         key_ff <= {entry_index, entry_page, entry_frame};
         op_ff  <= req_op;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_found_ff  <= cmd.res_found;
         res_frame_ff  <= cmd.res_take_frame ? rd_data_ff[FIELD_W-1:0] : '0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_found_ff  <= res_found_ff;
         out_frame_ff  <= res_frame_ff;
         out_occ_ff    <= OCC_W'(count_ff);
      end
   end

   always_comb begin
      if (op_ff == OP_REMOVE) begin
         match = (rd_data_ff == key_ff);
      end else begin
         match = (rd_data_ff[FIELD_W-1:0] == key_ff[FIELD_W-1:0]);
      end
   end

   assign stat.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty      = (count_ff == '0);
   assign stat.cmp_valid  = cmp_valid_ff;
   assign stat.cmp_hit    = cmp_valid_ff && match;
   assign stat.cmp_at_end = (SUM_W'(cmp_pos_ff) + SUM_W'(1)) >= SUM_W'(count_ff);
   assign stat.op         = op_ff;

   assign status        = out_status_ff;
   assign found         = out_found_ff;
   assign removed_frame = out_frame_ff;
   assign occupancy     = out_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      shift_wr |-> (wr_addr_ff != ptr_ff))
      else $error("gap closing writes where it is still reading");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.do_pop |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not lower the count by one");

endmodule

// ===== src/oqsr_ctrl.sv =====
// Controller: sequences dispatch, scan, gap closing and result handoff.
module oqsr_ctrl
   import oqsr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  op_type   req_op,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.res_status = STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.res_set = 1'b1;
               state_in    = ST_RESULT;
               unique case (req_op)
                  OP_APPEND: begin
                     if (stat.full) begin
                        cmd.res_status = STAT_FULL;
                     end else begin
                        cmd.do_append = 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (stat.empty) begin
                        cmd.res_status = STAT_EMPTY;
                     end else begin
                        cmd.do_pop = 1'b1;
                     end
                  end
                  OP_REMOVE, OP_CONTAINS: begin
                     if (stat.empty) begin
                        cmd.res_status = (req_op == OP_REMOVE) ? STAT_NOT_FOUND : STAT_OK;
                     end else begin
                        cmd.res_set    = 1'b0;
                        cmd.latch_req  = 1'b1;
                        cmd.start_scan = 1'b1;
                        state_in       = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.cmp_hit) begin
               cmd.res_set   = 1'b1;
               cmd.res_found = 1'b1;
               if (stat.op == OP_REMOVE) begin
                  cmd.res_take_frame = 1'b1;
                  cmd.mark_hit       = 1'b1;
                  state_in           = ST_SHIFT;
               end else begin
                  state_in = ST_RESULT;
               end
            end else if (stat.cmp_valid && stat.cmp_at_end) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = (stat.op == OP_REMOVE) ? STAT_NOT_FOUND : STAT_OK;
               state_in       = ST_RESULT;
            end
         end
         ST_SHIFT: begin
            cmd.scan_en  = 1'b1;
            cmd.shift_en = 1'b1;
            if (stat.cmp_at_end) begin
               cmd.dec_count = 1'b1;
               state_in      = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while holding an untaken result");

   a_shift_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> ($past(state_ff) == ST_SCAN || $past(state_ff) == ST_SHIFT))
      else $error("gap closing entered without a scan hit");

   a_valid_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESULT))
      else $error("result presented outside the result state");

endmodule
